### design/vpf_pkg.sv
package vpf_pkg;

    // longest packet and byte counter width
    localparam int PKT_MAX = 9;
    localparam int IDX_W   = 4;

    // packet byte codes
    localparam logic [7:0] HDR_ADDR   = 8'h81;
    localparam logic [7:0] HDR_CMD    = 8'h01;
    localparam logic [7:0] TERM_BYTE  = 8'hFF;
    localparam logic [7:0] CAT_PTZ    = 8'h06;
    localparam logic [7:0] CAT_CAM    = 8'h04;
    localparam logic [7:0] OP_DRIVE   = 8'h01;
    localparam logic [7:0] OP_HOME    = 8'h04;
    localparam logic [7:0] OP_MENU    = 8'h06;
    localparam logic [7:0] OP_ZOOM    = 8'h07;
    localparam logic [7:0] MENU_OPEN  = 8'h02;
    localparam logic [7:0] DIR_NONE   = 8'h03;
    localparam logic [7:0] DIR_LEFT   = 8'h01;
    localparam logic [7:0] DIR_RIGHT  = 8'h02;
    localparam logic [7:0] DIR_UP     = 8'h01;
    localparam logic [7:0] DIR_DOWN   = 8'h02;
    localparam logic [7:0] ZOOM_TELE  = 8'h20;
    localparam logic [7:0] ZOOM_WIDE  = 8'h30;
    localparam logic [7:0] PAN_MAX    = 8'd24;
    localparam logic [7:0] TILT_MAX   = 8'd20;
    localparam logic [7:0] ZOOM_MAX   = 8'd7;

    // packet lengths
    localparam logic [IDX_W-1:0] LEN_DRIVE = 4'd9;
    localparam logic [IDX_W-1:0] LEN_ZOOM  = 4'd6;
    localparam logic [IDX_W-1:0] LEN_HOME  = 4'd5;
    localparam logic [IDX_W-1:0] LEN_MENU  = 4'd6;

    typedef enum logic [2:0] {
        CMD_PAN_TILT = 3'd0,
        CMD_ZOOM     = 3'd1,
        CMD_HOME     = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_MENU     = 3'd4
    } vpf_cmd_t;

    // one framed packet handed from encoder to serializer
    typedef struct packed {
        logic                       emit;
        logic [IDX_W-1:0]           len;
        logic [PKT_MAX-1:0][7:0]    bytes;
    } vpf_pkt_t;

endpackage

### design/vpf_if.sv
interface vpf_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic signed [7:0] pan_speed;
    logic signed [7:0] tilt_speed;
    logic signed [7:0] zoom_speed;

    modport source (output valid, output cmd, output pan_speed, output tilt_speed,
                    output zoom_speed, input ready);
    modport sink (input valid, input cmd, input pan_speed, input tilt_speed,
                  input zoom_speed, output ready);
endinterface

interface vpf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface vpf_cfg_if;
    logic valid;
    logic ready;
    logic link_enable;

    modport source (output valid, output link_enable, input ready);
    modport sink (input valid, input link_enable, output ready);
endinterface

### design/visca_ptz_command_framer.sv
// flow: an accepted command request is first held in the packet buffer; its first byte
// then moves into the byte output register, from which the packet channel takes it
// throughput: one packet byte per cycle through the single byte output register while
// the packet channel is ready; a dropped command sends no bytes
// reset: link disabled, stored pan/tilt/zoom speeds zero, packet buffer and output empty
module visca_ptz_command_framer
    import vpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vpf_cmd_if.sink     command,
    vpf_byte_if.source  packet,
    vpf_cfg_if.sink     setup
);

    logic     link_enable_reg;
    logic     take;
    logic     load_ready;
    vpf_pkt_t pkt;

    // link enable register, always writable
    assign setup.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_enable_reg <= 1'b0;
        end
        else if (setup.valid)
        begin
            link_enable_reg <= setup.link_enable;
        end
    end

    // command request handshake
    assign command.ready = load_ready;
    assign take          = command.valid && load_ready;

    vpf_encoder u_encoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .link_enable (link_enable_reg),
        .cmd         (command.cmd),
        .pan_speed   (command.pan_speed),
        .tilt_speed  (command.tilt_speed),
        .zoom_speed  (command.zoom_speed),
        .pkt         (pkt)
    );

    vpf_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .pkt        (pkt),
        .load_ready (load_ready),
        .out_valid  (packet.valid),
        .out_ready  (packet.ready),
        .out_byte   (packet.packet_byte),
        .out_last   (packet.last_byte)
    );

endmodule

### design/vpf_encoder.sv
module vpf_encoder
    import vpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic             link_enable,
    input  logic [2:0]       cmd,
    input  logic [7:0]       pan_speed,
    input  logic [7:0]       tilt_speed,
    input  logic [7:0]       zoom_speed,
    output vpf_pkt_t         pkt
);

    logic [7:0] prev_pan_reg;
    logic [7:0] prev_pan_next;
    logic [7:0] prev_tilt_reg;
    logic [7:0] prev_tilt_next;
    logic [7:0] prev_zoom_reg;
    logic [7:0] prev_zoom_next;
    logic       pt_same;
    logic       zoom_same;

    // saturated magnitude of a two's complement byte
    function automatic logic [7:0] sat_mag(input logic [7:0] raw, input logic [7:0] lim);
        logic [8:0] mag;
        mag = raw[7] ? (9'd256 - {1'b0, raw}) : {1'b0, raw};
        return (mag > {1'b0, lim}) ? lim : mag[7:0];
    endfunction

    assign pt_same   = (pan_speed == prev_pan_reg) && (tilt_speed == prev_tilt_reg);
    assign zoom_same = (zoom_speed == prev_zoom_reg);

    // packet build and stored speed update
    always_comb
    begin
        pkt            = '0;
        pkt.bytes[0]   = HDR_ADDR;
        pkt.bytes[1]   = HDR_CMD;
        prev_pan_next  = prev_pan_reg;
        prev_tilt_next = prev_tilt_reg;
        prev_zoom_next = prev_zoom_reg;
        unique case (vpf_cmd_t'(cmd))
            CMD_PAN_TILT:
            begin
                pkt.emit     = link_enable && !pt_same;
                pkt.len      = LEN_DRIVE;
                pkt.bytes[2] = CAT_PTZ;
                pkt.bytes[3] = OP_DRIVE;
                pkt.bytes[4] = sat_mag(pan_speed, PAN_MAX);
                pkt.bytes[5] = sat_mag(tilt_speed, TILT_MAX);
                pkt.bytes[6] = (pan_speed == 8'd0) ? DIR_NONE :
                               (pan_speed[7] ? DIR_LEFT : DIR_RIGHT);
                pkt.bytes[7] = (tilt_speed == 8'd0) ? DIR_NONE :
                               (tilt_speed[7] ? DIR_DOWN : DIR_UP);
                pkt.bytes[8] = TERM_BYTE;
                if (pkt.emit)
                begin
                    prev_pan_next  = pan_speed;
                    prev_tilt_next = tilt_speed;
                end
            end
            CMD_ZOOM:
            begin
                pkt.emit     = link_enable && !zoom_same;
                pkt.len      = LEN_ZOOM;
                pkt.bytes[2] = CAT_CAM;
                pkt.bytes[3] = OP_ZOOM;
                pkt.bytes[4] = (zoom_speed == 8'd0) ? 8'd0 :
                               ((zoom_speed[7] ? ZOOM_WIDE : ZOOM_TELE)
                                | sat_mag(zoom_speed, ZOOM_MAX));
                pkt.bytes[5] = TERM_BYTE;
                if (pkt.emit)
                begin
                    prev_zoom_next = zoom_speed;
                end
            end
            CMD_HOME:
            begin
                pkt.emit     = link_enable;
                pkt.len      = LEN_HOME;
                pkt.bytes[2] = CAT_PTZ;
                pkt.bytes[3] = OP_HOME;
                pkt.bytes[4] = TERM_BYTE;
            end
            CMD_STOP:
            begin
                pkt.emit     = link_enable;
                pkt.len      = LEN_DRIVE;
                pkt.bytes[2] = CAT_PTZ;
                pkt.bytes[3] = OP_DRIVE;
                pkt.bytes[6] = DIR_NONE;
                pkt.bytes[7] = DIR_NONE;
                pkt.bytes[8] = TERM_BYTE;
                if (link_enable)
                begin
                    prev_pan_next  = '0;
                    prev_tilt_next = '0;
                    prev_zoom_next = '0;
                end
            end
            CMD_MENU:
            begin
                pkt.emit     = link_enable;
                pkt.len      = LEN_MENU;
                pkt.bytes[2] = CAT_PTZ;
                pkt.bytes[3] = OP_MENU;
                pkt.bytes[4] = MENU_OPEN;
                pkt.bytes[5] = TERM_BYTE;
            end
            default:
            begin
                pkt.emit = 1'b0;
            end
        endcase
    end

    // stored speeds change only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pan_reg  <= '0;
            prev_tilt_reg <= '0;
            prev_zoom_reg <= '0;
        end
        else if (take)
        begin
            prev_pan_reg  <= prev_pan_next;
            prev_tilt_reg <= prev_tilt_next;
            prev_zoom_reg <= prev_zoom_next;
        end
    end

endmodule

### design/vpf_serializer.sv
module vpf_serializer
    import vpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  vpf_pkt_t   pkt,
    output logic       load_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [PKT_MAX-1:0][7:0] buf_reg;
    logic [IDX_W-1:0]        len_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    busy_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_byte_reg;
    logic                    out_last_reg;
    logic                    move;
    logic                    last_move;
    logic                    load;

    // byte transfer from packet buffer into the output register
    assign move       = busy_reg && (!out_valid_reg || out_ready);
    assign last_move  = move && (idx_reg == (len_reg - 4'd1));
    assign load_ready = !busy_reg || last_move;
    assign load       = take && pkt.emit;

    // packet buffer and byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (last_move)
        begin
            busy_reg <= 1'b0;
        end
        else if (move)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= pkt.bytes;
            len_reg <= pkt.len;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_byte_reg <= buf_reg[idx_reg];
            out_last_reg <= last_move;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // counter stays inside the packet
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < len_reg))
        else $error("byte counter past packet length");

    // a new packet never overwrites one still in flight
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && busy_reg) |-> last_move)
        else $error("packet buffer overwritten");

    // only known packet lengths are held
    a_len_known: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (len_reg == LEN_DRIVE || len_reg == LEN_ZOOM || len_reg == LEN_HOME))
        else $error("unexpected packet length");

    // every packet opens with the address byte
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && idx_reg == '0) |-> (buf_reg[0] == HDR_ADDR))
        else $error("packet without address header");

    // last flag marks the terminator byte
    a_last_term: assert property (@(posedge clk) disable iff (!rst_n)
        last_move |-> (buf_reg[idx_reg] == TERM_BYTE))
        else $error("last byte is not the terminator");

endmodule
